>>> hw/rtl/jsf_pkg.sv
// Shared constants and types for the joystick smoothing filter.
// No dependencies; used by the top level and its port checker.
package jsf_pkg;

	localparam int AXIS_W     = 10;
	localparam int LEVEL_W    = 9;
	localparam int SLEW_W     = 10;
	localparam int TDATA_W    = 24;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [SLEW_W-1:0]  SLEW_RST  = 10'd64;
	localparam logic [LEVEL_W-1:0] LEAVE_RST = 9'd77;
	localparam logic [LEVEL_W-1:0] ENTER_RST = 9'd41;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_SLEW_LIMIT  = 2'd0,
		REG_LEAVE_LEVEL = 2'd1,
		REG_ENTER_LEVEL = 2'd2
	} cfg_reg_t;

	typedef logic signed [AXIS_W-1:0] axis_t;

endpackage

>>> hw/rtl/joystick_smoothing_filter.sv
// Joystick smoothing filter: moving average, slew limit and zero lock with hysteresis.
// Depends on jsf_pkg. Sample history is kept in an internal synchronous memory.
//
// Usage:
//   s_tdata carries one raw sample pair per beat; m_tdata returns one filtered pair per
//   input beat, in order. Configuration (slew_limit, leave_level, enter_level) is written
//   through cfg_we/cfg_addr/cfg_wdata while no sample is in flight.
//   Pipeline: a sample accepted at one clock edge passes through the history read, running
//   sum update, divide multiply and slew/lock stages in turn before it shows on m_tvalid.
//   Throughput: one sample per cycle while the output is not stalled. The history
//   memory is read at the accept edge and written back as the sample leaves the first
//   stage; a write to the slot being read is forwarded. The slew and lock state closes
//   its loop within the last stage, so consecutive samples need no gap.
//   Stall: each stage advances when the next one is empty or moving, so bubbles are
//   squeezed out; s_tready drops only when all four stages hold a sample and m_tready
//   is low. A held output beat keeps its data.
//   Reset: arst_n clears the history (per-entry valid bits), the running sums, the slew
//   reference, sets both axes locked and restores the register defaults.
module joystick_smoothing_filter #(
	parameter int WINDOW = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [jsf_pkg::TDATA_W-1:0]       s_tdata,   // raw_x[9:0], raw_y[19:10], zero pad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [jsf_pkg::TDATA_W-1:0]       m_tdata,   // smooth_x[9:0], smooth_y[19:10], zero pad
	input  logic                              cfg_we,
	input  logic [jsf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [jsf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int AW      = jsf_pkg::AXIS_W;
	localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int LOG_W   = $clog2(WINDOW);
	localparam int SUM_W   = AW + LOG_W;
	// Exact floor division by WINDOW for magnitudes below 2**SUM_W
	localparam int SH      = SUM_W + LOG_W;
	localparam int RECIP_W = SH + 1;
	localparam int RECIP   = ((1 << SH) + WINDOW - 1) / WINDOW;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
	localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(WINDOW - 1);

	// configuration
	logic [jsf_pkg::SLEW_W-1:0]  slew_q;
	logic [jsf_pkg::LEVEL_W-1:0] leave_q;
	logic [jsf_pkg::LEVEL_W-1:0] enter_q;

	// handshake and stage control
	logic vld_s1, vld_s2, vld_s3, out_vld_q;
	logic adv2, adv3, advo;
	logic acc, mv2, mv_o;

	// history memory: {raw_y, raw_x}
	logic [2*AW-1:0]   hist_mem [WINDOW];
	logic [WINDOW-1:0] hist_vld_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_s1;
	logic [2*AW-1:0]   raw_s1;
	logic [2*AW-1:0]   rd_data_s1;
	logic              rd_live_s1;
	logic              fwd_hit;
	logic              rd_live;

	// per-axis datapath
	logic signed [SUM_W-1:0]  sum_q   [2];
	logic signed [SUM_W-1:0]  sum_nx  [2];
	logic signed [SUM_W-1:0]  sum_s2  [2];
	logic [SUM_W-1:0]         mag_s2c [2];
	logic [PROD_W-1:0]        prod_s3 [2];
	logic                     neg_s3  [2];
	jsf_pkg::axis_t           last_q  [2];
	logic                     lock_q  [2];
	jsf_pkg::axis_t           val_nx  [2];
	logic                     lock_nx [2];
	jsf_pkg::axis_t           out_q   [2];

	assign advo     = !out_vld_q || m_tready;
	assign adv3     = !vld_s3 || advo;
	assign adv2     = !vld_s2 || adv3;
	assign s_tready = !vld_s1 || adv2;
	assign acc      = s_tvalid && s_tready;
	assign mv2      = vld_s1 && adv2;
	assign mv_o     = vld_s3 && advo;

	assign fwd_hit = mv2 && (slot_s1 == slot_q);
	assign rd_live = fwd_hit || hist_vld_q[slot_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slew_q  <= jsf_pkg::SLEW_RST;
			leave_q <= jsf_pkg::LEAVE_RST;
			enter_q <= jsf_pkg::ENTER_RST;
		end else if (cfg_we) begin
			case (jsf_pkg::cfg_reg_t'(cfg_addr))
				jsf_pkg::REG_SLEW_LIMIT:  slew_q  <= cfg_wdata;
				jsf_pkg::REG_LEAVE_LEVEL: leave_q <= cfg_wdata[jsf_pkg::LEVEL_W-1:0];
				jsf_pkg::REG_ENTER_LEVEL: enter_q <= cfg_wdata[jsf_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			out_vld_q  <= 1'b0;
			slot_q     <= '0;
			hist_vld_q <= '0;
		end else begin
			if (s_tready) vld_s1    <= s_tvalid;
			if (adv2)     vld_s2    <= vld_s1;
			if (adv3)     vld_s3    <= vld_s2;
			if (advo)     out_vld_q <= vld_s3;
			if (acc) begin
				slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
			end
			if (mv2) hist_vld_q[slot_s1] <= 1'b1;
		end
	end

	// history read at accept, write back as the sample leaves the first stage
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_data_s1 <= fwd_hit ? raw_s1 : hist_mem[slot_q];
			rd_live_s1 <= rd_live;
			raw_s1     <= s_tdata[2*AW-1:0];
			slot_s1    <= slot_q;
		end
		if (mv2) hist_mem[slot_s1] <= raw_s1;
	end

	for (genvar a = 0; a < 2; a++) begin : g_axis
		jsf_pkg::axis_t          raw_a, old_a, val_a, quo_abs;
		logic [AW-1:0]           quo;
		logic signed [AW:0]      avg;
		logic signed [AW+1:0]    dlt, dlt_c, lim, val_w;
		logic [AW-1:0]           mag;

		assign raw_a = raw_s1[a*AW +: AW];
		assign old_a = rd_live_s1 ? rd_data_s1[a*AW +: AW] : '0;
		assign sum_nx[a] = sum_q[a] - SUM_W'(old_a) + SUM_W'(raw_a);
		assign mag_s2c[a] = sum_s2[a][SUM_W-1] ? SUM_W'(-sum_s2[a]) : SUM_W'(sum_s2[a]);

		// truncating quotient, sign restored afterwards
		assign quo   = prod_s3[a][SH +: AW];
		assign avg   = neg_s3[a] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		assign lim   = $signed({2'b00, slew_q});
		assign dlt   = (AW+2)'(avg) - (AW+2)'(last_q[a]);
		assign dlt_c = (dlt > lim) ? lim : ((dlt < -lim) ? -lim : dlt);
		assign val_w = (AW+2)'(last_q[a]) + dlt_c;
		assign val_a = val_w[AW-1:0];
		assign quo_abs = -val_a;
		assign mag   = val_a[AW-1] ? quo_abs : val_a;

		always_comb begin
			val_nx[a]  = val_a;
			lock_nx[a] = lock_q[a];
			if (lock_q[a]) begin
				if (mag > {1'b0, leave_q}) lock_nx[a] = 1'b0;
				else                       val_nx[a]  = '0;
			end else if (mag < {1'b0, enter_q}) begin
				lock_nx[a] = 1'b1;
				val_nx[a]  = '0;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sum_q[a]  <= '0;
				last_q[a] <= '0;
				lock_q[a] <= 1'b1;
			end else begin
				if (mv2) sum_q[a] <= sum_nx[a];
				if (mv_o) begin
					last_q[a] <= val_nx[a];
					lock_q[a] <= lock_nx[a];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv2) sum_s2[a] <= sum_nx[a];
			if (adv3) begin
				prod_s3[a] <= PROD_W'(mag_s2c[a]) * PROD_W'(RECIP_V);
				neg_s3[a]  <= sum_s2[a][SUM_W-1];
			end
			if (mv_o) out_q[a] <= val_nx[a];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(jsf_pkg::TDATA_W - 2*AW)'(0), out_q[1], out_q[0]};

endmodule

>>> hw/rtl/jsf_checker.sv
// Port-level checker for the joystick smoothing filter, bound to the top level.
// Depends on jsf_pkg; watches only the top-level ports.
module jsf_port_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [jsf_pkg::TDATA_W-1:0]    s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [jsf_pkg::TDATA_W-1:0]    m_tdata
);

	logic [2:0] inflight_q;
	logic       in_beat, out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	// count samples between input beat and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({in_beat, out_beat})
				2'b10:   inflight_q <= inflight_q + 3'd1;
				2'b01:   inflight_q <= inflight_q - 3'd1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("more samples in flight than pipeline stages");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 3'd0)
		else $error("output beat without a pending sample");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> inflight_q == 3'd4 && !m_tready)
		else $error("input stalled while pipeline has room");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[jsf_pkg::TDATA_W-1:20] == '0)
		else $error("nonzero pad bits on output beat");

endmodule

bind joystick_smoothing_filter jsf_port_checker u_jsf_checker (.*);

>>> tb/jsf_checker.sv
// Port checker for the joystick smoothing filter: predicts each output beat from the
// input beats and register writes it sees, and compares field by field.
// Depends on jsf_pkg.
module jsf_checker
	import jsf_pkg::*;
#(
	parameter int WINDOW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [TDATA_W-1:0]    s_tdata,     // raw_x[9:0], raw_y[19:10], zero pad
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [TDATA_W-1:0]    m_tdata,     // smooth_x[9:0], smooth_y[19:10], zero pad
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		axis_t y;
		axis_t x;
	} smooth_pair_t;

	logic [SLEW_W-1:0]  slew_limit;
	logic [LEVEL_W-1:0] leave_level;
	logic [LEVEL_W-1:0] enter_level;

	axis_t axis_hist [2][WINDOW];
	int    axis_sum  [2];
	axis_t axis_last [2];
	bit    axis_locked [2];
	int    slot;

	smooth_pair_t pending_pairs [$];

	// One axis through average, slew clamp and zero lock; updates that axis's state.
	function automatic axis_t filter_axis(int a, axis_t raw);
		int avg;
		int step;
		int lim;
		int val;
		int mag;
		lim = int'(slew_limit);
		axis_sum[a] = axis_sum[a] - int'(axis_hist[a][slot]) + int'(raw);
		axis_hist[a][slot] = raw;
		avg = axis_sum[a] / WINDOW;
		step = avg - int'(axis_last[a]);
		if (step > lim)
			step = lim;
		if (step < -lim)
			step = -lim;
		val = int'(axis_last[a]) + step;
		mag = (val < 0) ? -val : val;
		if (axis_locked[a]) begin
			if (mag > int'(leave_level))
				axis_locked[a] = 1'b0;
			else
				val = 0;
		end else if (mag < int'(enter_level)) begin
			axis_locked[a] = 1'b1;
			val = 0;
		end
		axis_last[a] = axis_t'(val);
		return axis_t'(val);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		smooth_pair_t want;
		smooth_pair_t head;
		axis_t got_x;
		axis_t got_y;
		int errs;
		if (!arst_n) begin
			slew_limit = SLEW_RST;
			leave_level = LEAVE_RST;
			enter_level = ENTER_RST;
			for (int a = 0; a < 2; a++) begin
				for (int i = 0; i < WINDOW; i++)
					axis_hist[a][i] = '0;
				axis_sum[a] = 0;
				axis_last[a] = '0;
				axis_locked[a] = 1'b1;
			end
			slot = 0;
			pending_pairs.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			// check the output side first: an output beat never belongs to this edge's input
			if (m_tvalid && m_tready) begin
				got_x = m_tdata[AXIS_W-1:0];
				got_y = m_tdata[2*AXIS_W-1:AXIS_W];
				if (pending_pairs.size() == 0) begin
					$display("%0t: unexpected output beat, got smooth_x=%0d smooth_y=%0d",
						$time, got_x, got_y);
					errs++;
				end else begin
					head = pending_pairs.pop_front();
					if (got_x !== head.x) begin
						$display("%0t: smooth_x expected %0d, got %0d", $time, head.x, got_x);
						errs++;
					end
					if (got_y !== head.y) begin
						$display("%0t: smooth_y expected %0d, got %0d", $time, head.y, got_y);
						errs++;
					end
					if (m_tdata[TDATA_W-1:2*AXIS_W] !== '0) begin
						$display("%0t: pad bits expected 0, got %0h", $time,
							m_tdata[TDATA_W-1:2*AXIS_W]);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want.x = filter_axis(0, axis_t'(s_tdata[AXIS_W-1:0]));
				want.y = filter_axis(1, axis_t'(s_tdata[2*AXIS_W-1:AXIS_W]));
				slot = (slot + 1) % WINDOW;
				pending_pairs.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_SLEW_LIMIT:  slew_limit = cfg_wdata[SLEW_W-1:0];
					REG_LEAVE_LEVEL: leave_level = cfg_wdata[LEVEL_W-1:0];
					REG_ENTER_LEVEL: enter_level = cfg_wdata[LEVEL_W-1:0];
					default: ;
				endcase
			end
			fail_count <= fail_count + errs;
			outstanding <= pending_pairs.size();
		end
	end

endmodule

>>> tb/testbench.sv
// Top of the joystick smoothing filter testbench: clock, reset, stimulus and verdict.
// Depends on jsf_pkg, joystick_smoothing_filter and jsf_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import jsf_pkg::*;

	localparam int N_ITEMS      = 900;
	localparam int RESET_CYCLES = 10;
	localparam int HOLD_CYCLES  = 48;
	localparam int TAIL_CYCLES  = 12;
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [TDATA_W-1:0]    s_tdata;     // raw_x[9:0], raw_y[19:10], zero pad
	logic                  m_tvalid;
	logic                  m_tready;
	logic [TDATA_W-1:0]    m_tdata;     // smooth_x[9:0], smooth_y[19:10], zero pad
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int fail_count;
	int outstanding;
	int sent = 0;
	bit quiet = 1'b0;
	int hold_reqs = 0;
	int holds_done = 0;
	int cur_leave = 77;
	int cur_enter = 41;

	always #1 clk = ~clk;

	joystick_smoothing_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	jsf_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// Output side: random back-pressure, plus a long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				m_tready <= quiet || ($urandom_range(99) >= 30);
			end
		end
	end

	task automatic offer_sample(int x, int y);
		if (!quiet && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(TDATA_W-2*AXIS_W){1'b0}}, axis_t'(y), axis_t'(x)};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Stop offering and hold until every expected beat has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val[CFG_DATA_W-1:0];
		@(posedge clk);
	endtask

	task automatic apply_config(int slew, int leave, int enter);
		drain();
		write_reg(REG_SLEW_LIMIT, slew);
		write_reg(REG_LEAVE_LEVEL, leave);
		write_reg(REG_ENTER_LEVEL, enter);
		cfg_we <= 1'b0;
		cur_leave = leave;
		cur_enter = enter;
	endtask

	// Favor values at or next to the current thresholds and the rails.
	function automatic int pick_target();
		int v;
		case ($urandom_range(7))
			0:       v = 511;
			1:       v = -512;
			2:       v = cur_leave;
			3:       v = cur_enter;
			4:       v = cur_leave + 1;
			5:       v = cur_enter - 1;
			6:       v = 0;
			default: v = int'(axis_t'($urandom_range(1023)));
		endcase
		if ($urandom_range(1))
			v = -v;
		if (v > 511)
			v = 511;
		if (v < -512)
			v = -512;
		return v;
	endfunction

	function automatic int pick_level();
		case ($urandom_range(3))
			0:       return 0;
			1:       return 511;
			2:       return $urandom_range(150, 20);
			default: return $urandom_range(511);
		endcase
	endfunction

	initial begin
		int phase;
		int phase_len;
		int n;
		int run_len;
		int x;
		int y;
		int slew;
		bit paused;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_addr <= REG_SLEW_LIMIT;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start-up ramp from the rails under reset settings
		repeat (8) offer_sample(511, -512);
		offer_sample(0, 0);
		offer_sample(-1, 1);
		// zero slew freezes both outputs
		apply_config(0, 77, 41);
		repeat (2) offer_sample(511, -512);
		// full-scale negative with the widest slew and lock thresholds
		apply_config(1023, 511, 0);
		repeat (8) offer_sample(-512, -512);
		// unused index is ignored, oversized values lose their top bit;
		// leaves enter above leave so the lock toggles
		drain();
		write_reg(REG_UNUSED, 0);
		write_reg(REG_LEAVE_LEVEL, 'h264);
		write_reg(REG_ENTER_LEVEL, 'h3FF);
		cfg_we <= 1'b0;
		cur_leave = 'h064;
		cur_enter = 'h1FF;
		repeat (4) offer_sample(200, -300);

		phase = 0;
		while (sent < N_ITEMS) begin
			case (phase)
				0:       apply_config(1023, 0, 0);
				1:       apply_config(1, 511, 511);
				default: begin
					case ($urandom_range(4))
						0:       slew = 0;
						1:       slew = 1;
						2:       slew = 1023;
						3:       slew = $urandom_range(256, 2);
						default: slew = $urandom_range(1023, 1);
					endcase
					apply_config(slew, pick_level(), pick_level());
				end
			endcase
			quiet = (phase == 2);
			if (phase % 3 == 1)
				hold_reqs <= hold_reqs + 1;
			paused = 1'b0;
			phase_len = $urandom_range(80, 40);
			n = 0;
			while (n < phase_len) begin
				if ($urandom_range(9) < 2) begin
					run_len = 1;
					x = int'(axis_t'($urandom_range(1023)));
					y = int'(axis_t'($urandom_range(1023)));
				end else begin
					run_len = $urandom_range(16, 1);
					x = pick_target();
					y = pick_target();
				end
				repeat (run_len) begin
					offer_sample(x, y);
					n++;
				end
				if (phase % 3 == 2 && !paused && n > phase_len / 2) begin
					drain();
					paused = 1'b1;
				end
			end
			phase++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
